// File: src/msr_pkg.sv
`timescale 1ns / 1ps

package msr_pkg;

  // upper bound of the non-residue search and the width of its counter
  localparam int unsigned NR_LIMIT = 4096;
  localparam int unsigned NW       = 13;

  typedef enum logic [4:0] {
    S_IDLE,
    S_RED,
    S_MWAIT,
    S_FIX,
    S_EUL,
    S_SHORT,
    S_SPLIT,
    S_NR,
    S_NRCHK,
    S_XS,
    S_BS,
    S_GST,
    S_LOOP,
    S_ORD,
    S_ORDSQ,
    S_GS,
    S_GX,
    S_GB,
    S_GE,
    S_P_TEST,
    S_P_ACC,
    S_P_SQ
  } msr_state_e;

endpackage

// File: src/msr_mulmod.sv
`timescale 1ns / 1ps

// (x * y) mod p, one bit of x per cycle, msb first; y must be below p
module msr_mulmod #(
  parameter int unsigned WIDTH = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [WIDTH-1:0] x_i,
  input  logic [WIDTH-1:0] y_i,
  input  logic [WIDTH-1:0] p_i,
  output logic             done_o,
  output logic [WIDTH-1:0] res_o
);
  localparam int unsigned CW = $clog2(WIDTH + 1);

  logic [WIDTH-1:0] x_q, y_q, acc_q, acc_d;
  logic [CW-1:0]    cnt_q;
  logic             run_q, done_q;
  logic [WIDTH:0]   dbl, dbl_r, sum, sum_r;

  always_comb begin
    dbl   = {acc_q, 1'b0};
    dbl_r = (dbl >= {1'b0, p_i}) ? dbl - {1'b0, p_i} : dbl;
    sum   = {1'b0, dbl_r[WIDTH-1:0]} + (x_q[WIDTH-1] ? {1'b0, y_q} : '0);
    sum_r = (sum >= {1'b0, p_i}) ? sum - {1'b0, p_i} : sum;
    acc_d = sum_r[WIDTH-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= CW'(WIDTH);
      end else if (run_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q   <= x_i;
      y_q   <= y_i;
      acc_q <= '0;
    end else if (run_q) begin
      x_q   <= {x_q[WIDTH-2:0], 1'b0};
      acc_q <= acc_d;
    end
  end

  assign done_o = done_q;
  assign res_o  = acc_q;

endmodule

// File: src/modular_square_root.sv
`timescale 1ns / 1ps

// channel   | direction | handshake             | payload
// ----------+-----------+-----------------------+--------------------------
// command   | in        | start, busy           | value_i, modulus_i
// result    | out       | done_o (one cycle)    | root_o, has_root_o
//
// one item at a time; busy is high from the cycle after the accepting edge
// and is already low in the cycle that shows the result strobe. every modular
// product goes through one shift-add mulmod unit (launch, WIDTH bit steps,
// done), plus a square update per exponent bit. an exponentiation takes up
// to 2*WIDTH products. the p = 3 mod 4 path runs two of them (euler check
// and shortcut power); tonelli-shanks adds the non-residue search, three
// setup powers and up to r*r squarings.
// reset clears the sequencer; no memories, so no clearing pass.
// the receiver cannot stall: the result is shown for exactly one cycle.
module modular_square_root #(
  parameter int unsigned WIDTH = 32
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  logic signed [WIDTH-1:0] value_i,
  input  logic        [WIDTH-1:0] modulus_i,
  output logic                    done_o,
  output logic        [WIDTH-1:0] root_o,
  output logic                    has_root_o
);
  import msr_pkg::*;

  localparam int unsigned RW = $clog2(WIDTH);
  localparam int unsigned LW = (WIDTH > NW) ? WIDTH : NW;

  msr_state_e state_q, state_d, mret_q, pret_q;

  // operand and working registers
  logic [WIDTH-1:0] p_q, a_q, s_q, x_q, b_q, g_q, t_q;
  logic [WIDTH-1:0] base_q, exp_q, acc_q;
  logic [RW-1:0]    r_q, m_q;
  logic [NW-1:0]    n_q, lim_q;
  logic             neg_q;

  // result registers
  logic [WIDTH-1:0] root_q;
  logic             has_q, done_q;

  // shared multiplier
  logic             mul_start, mul_done;
  logic [WIDTH-1:0] mul_x, mul_y, mul_res;

  // finish request from the sequencer
  logic             fin, fin_ok;
  logic [WIDTH-1:0] fin_root;

  // helpers
  logic [WIDTH-1:0] pm1, half_pm1, mag, red_a, ord_exp;
  logic [NW-1:0]    lim_d;
  logic             ord_more;

  assign pm1      = p_q - 1'b1;
  assign half_pm1 = pm1 >> 1;
  assign mag      = value_i[WIDTH-1] ? WIDTH'(-value_i) : WIDTH'(value_i);
  // fold the magnitude remainder back for negative inputs
  assign red_a    = (neg_q && mul_res != '0) ? p_q - mul_res : mul_res;
  assign ord_more = (m_q < r_q) && (t_q != WIDTH'(1));
  assign ord_exp  = WIDTH'(1) << (r_q - m_q - 1'b1);
  assign lim_d    = (LW'(pm1) < LW'(NR_LIMIT)) ? NW'(pm1) : NW'(NR_LIMIT);

  msr_mulmod #(.WIDTH(WIDTH)) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .x_i     (mul_x),
    .y_i     (mul_y),
    .p_i     (p_q),
    .done_o  (mul_done),
    .res_o   (mul_res)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (start) state_d = S_RED;
      S_RED:    state_d = S_MWAIT;
      S_MWAIT:  if (mul_done) state_d = mret_q;
      S_FIX: begin
        if (p_q < WIDTH'(3) || red_a == '0) state_d = S_IDLE;
        else state_d = S_P_TEST;
      end
      S_EUL: begin
        if (acc_q != WIDTH'(1)) state_d = S_IDLE;
        else if (p_q[1:0] == 2'b11) state_d = S_P_TEST;
        else state_d = S_SPLIT;
      end
      S_SHORT:  state_d = S_IDLE;
      S_SPLIT:  if (s_q[0]) state_d = S_NR;
      S_NR:     state_d = S_P_TEST;
      S_NRCHK: begin
        if (acc_q == pm1) state_d = S_P_TEST;
        else if (n_q + 1'b1 > lim_q) state_d = S_IDLE;
        else state_d = S_NR;
      end
      S_XS:     state_d = S_P_TEST;
      S_BS:     state_d = S_P_TEST;
      S_GST:    state_d = S_LOOP;
      S_LOOP:   state_d = S_ORD;
      S_ORD: begin
        if (ord_more) state_d = S_MWAIT;
        else if (m_q == '0 || m_q >= r_q) state_d = S_IDLE;
        else state_d = S_P_TEST;
      end
      S_ORDSQ:  state_d = S_ORD;
      S_GS:     state_d = S_MWAIT;
      S_GX:     state_d = S_MWAIT;
      S_GB:     state_d = S_MWAIT;
      S_GE:     state_d = S_LOOP;
      S_P_TEST: state_d = (exp_q == '0) ? pret_q : S_MWAIT;
      S_P_ACC:  state_d = S_MWAIT;
      S_P_SQ:   state_d = S_P_TEST;
      default:  state_d = S_IDLE;
    endcase
  end

  // multiplier launches and finish requests
  always_comb begin
    mul_start = 1'b0;
    mul_x     = '0;
    mul_y     = '0;
    fin       = 1'b0;
    fin_ok    = 1'b0;
    fin_root  = '0;
    case (state_q)
      S_RED: begin
        mul_start = 1'b1;
        mul_x     = t_q;
        mul_y     = WIDTH'(1);
      end
      S_FIX: begin
        if (p_q < WIDTH'(3)) begin
          fin = 1'b1;
        end else if (red_a == '0) begin
          fin    = 1'b1;
          fin_ok = 1'b1;
        end
      end
      S_EUL:   fin = (acc_q != WIDTH'(1));
      S_SHORT: begin
        fin      = 1'b1;
        fin_ok   = 1'b1;
        fin_root = acc_q;
      end
      S_NRCHK: fin = (acc_q != pm1) && (n_q + 1'b1 > lim_q);
      S_ORD: begin
        if (ord_more) begin
          mul_start = 1'b1;
          mul_x     = t_q;
          mul_y     = t_q;
        end else if (m_q == '0) begin
          fin      = 1'b1;
          fin_ok   = 1'b1;
          fin_root = x_q;
        end else if (m_q >= r_q) begin
          fin = 1'b1;
        end
      end
      S_GS: begin
        mul_start = 1'b1;
        mul_x     = acc_q;
        mul_y     = acc_q;
      end
      S_GX: begin
        mul_start = 1'b1;
        mul_x     = x_q;
        mul_y     = acc_q;
      end
      S_GB: begin
        mul_start = 1'b1;
        mul_x     = b_q;
        mul_y     = g_q;
      end
      S_P_TEST: begin
        if (exp_q != '0) begin
          mul_start = 1'b1;
          mul_x     = exp_q[0] ? acc_q : base_q;
          mul_y     = base_q;
        end
      end
      S_P_ACC: begin
        mul_start = 1'b1;
        mul_x     = base_q;
        mul_y     = base_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= fin;
    end
  end

  // datapath registers, written per sequencer step
  always_ff @(posedge clk_i) begin
    if (fin) begin
      root_q <= fin_root;
      has_q  <= fin_ok;
    end
    case (state_q)
      S_IDLE: begin
        if (start) begin
          p_q   <= modulus_i;
          neg_q <= value_i[WIDTH-1];
          t_q   <= mag;
        end
      end
      S_RED:   mret_q <= S_FIX;
      S_FIX: begin
        a_q    <= red_a;
        base_q <= red_a;
        exp_q  <= half_pm1;
        acc_q  <= WIDTH'(1);
        pret_q <= S_EUL;
      end
      S_EUL: begin
        // (p+1)/4 written without the overflowing add
        base_q <= a_q;
        exp_q  <= (p_q >> 2) + 1'b1;
        acc_q  <= WIDTH'(1);
        pret_q <= S_SHORT;
        s_q    <= pm1;
        r_q    <= '0;
      end
      S_SPLIT: begin
        if (!s_q[0]) begin
          s_q <= s_q >> 1;
          r_q <= r_q + 1'b1;
        end else begin
          n_q   <= NW'(2);
          lim_q <= lim_d;
        end
      end
      S_NR: begin
        base_q <= WIDTH'(n_q);
        exp_q  <= half_pm1;
        acc_q  <= WIDTH'(1);
        pret_q <= S_NRCHK;
      end
      S_NRCHK: begin
        if (acc_q == pm1) begin
          base_q <= a_q;
          exp_q  <= (s_q >> 1) + 1'b1;
          acc_q  <= WIDTH'(1);
          pret_q <= S_XS;
        end else begin
          n_q <= n_q + 1'b1;
        end
      end
      S_XS: begin
        x_q    <= acc_q;
        base_q <= a_q;
        exp_q  <= s_q;
        acc_q  <= WIDTH'(1);
        pret_q <= S_BS;
      end
      S_BS: begin
        b_q    <= acc_q;
        base_q <= WIDTH'(n_q);
        exp_q  <= s_q;
        acc_q  <= WIDTH'(1);
        pret_q <= S_GST;
      end
      S_GST:   g_q <= acc_q;
      S_LOOP: begin
        t_q <= b_q;
        m_q <= '0;
      end
      S_ORD: begin
        if (ord_more) begin
          mret_q <= S_ORDSQ;
        end else begin
          base_q <= g_q;
          exp_q  <= ord_exp;
          acc_q  <= WIDTH'(1);
          pret_q <= S_GS;
        end
      end
      S_ORDSQ: begin
        t_q <= mul_res;
        m_q <= m_q + 1'b1;
      end
      S_GS:    mret_q <= S_GX;
      S_GX: begin
        g_q    <= mul_res;
        mret_q <= S_GB;
      end
      S_GB: begin
        x_q    <= mul_res;
        mret_q <= S_GE;
      end
      S_GE: begin
        b_q <= mul_res;
        r_q <= m_q;
      end
      S_P_TEST: begin
        if (exp_q != '0) mret_q <= exp_q[0] ? S_P_ACC : S_P_SQ;
      end
      S_P_ACC: begin
        acc_q  <= mul_res;
        mret_q <= S_P_SQ;
      end
      S_P_SQ: begin
        base_q <= mul_res;
        exp_q  <= exp_q >> 1;
      end
      default: begin
      end
    endcase
  end

  assign busy       = (state_q != S_IDLE);
  assign done_o     = done_q;
  assign root_o     = root_q;
  assign has_root_o = has_q;

endmodule

// File: src/msr_checker.sv
`timescale 1ns / 1ps

module msr_checker #(
  parameter int unsigned WIDTH = 32
) (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             start,
  input logic             busy,
  input logic             done_o,
  input logic [WIDTH-1:0] root_o,
  input logic             has_root_o
);

  // an accepted item keeps the block busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  // a result only follows work in progress
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ($past(busy) && !busy))
    else $error("result strobe without a finished item");

  // a strobe lasts one cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  // no root means a zero root
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !has_root_o) |-> (root_o == '0))
    else $error("nonzero root reported without a root");

endmodule

bind modular_square_root msr_checker #(.WIDTH(WIDTH)) u_msr_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .start      (start),
  .busy       (busy),
  .done_o     (done_o),
  .root_o     (root_o),
  .has_root_o (has_root_o)
);
